FILE: sv/priority_hashed_bucket_queue_assert.svh
// Assertion macros used by the priority bucket queue checker.
`ifndef PRIORITY_HASHED_BUCKET_QUEUE_ASSERT_SVH
`define PRIORITY_HASHED_BUCKET_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PHQ_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PHQ_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/phq_pkg.sv
// Shared types and constants for the priority bucket queue.
package phq_pkg;

  localparam int REQ_ID_W   = 32;
  localparam int HANDLE_W   = 16;
  localparam int STATUS_W   = 2;
  localparam int BUCKET_W   = 4;
  localparam int TOTAL_W    = 8;
  localparam int URGENT_Q_W = 5;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STS_FULL  = 2'd2;

  typedef struct packed {
    logic accept;
    logic store_rd;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_deq;
    logic fifo_empty;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: sv/phq_req_if.sv
// Request channel interface of the priority bucket queue.
interface phq_req_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [phq_pkg::REQ_ID_W-1:0]  req_id;
  logic                          urgent;
  logic [phq_pkg::HANDLE_W-1:0]  handle;

  modport source (output valid, op, req_id, urgent, handle, input ready);
  modport sink (input valid, op, req_id, urgent, handle, output ready);
endinterface

FILE: sv/phq_rsp_if.sv
// Result channel interface of the priority bucket queue.
interface phq_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [phq_pkg::STATUS_W-1:0]    status;
  logic [phq_pkg::HANDLE_W-1:0]    out_handle;
  logic [phq_pkg::BUCKET_W-1:0]    bucket;
  logic [phq_pkg::TOTAL_W-1:0]     total_queued;
  logic [phq_pkg::URGENT_Q_W-1:0]  urgent_queued;

  modport source (output valid, status, out_handle, bucket, total_queued, urgent_queued,
                  input ready);
  modport sink (input valid, status, out_handle, bucket, total_queued, urgent_queued,
                output ready);
endinterface

FILE: sv/phq_ctrl.sv
// Sequencing state machine of the priority bucket queue.
module phq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output phq_pkg::ctrl_cmd_t  cmd,
  input  phq_pkg::dp_stat_t   stat
);

  typedef enum logic [1:0] {ST_IDLE, ST_META, ST_POP} state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   pop_go;
  logic   commit_go;

  always_comb begin
    pop_go    = (state_r == ST_META) && stat.is_deq && !stat.fifo_empty;
    commit_go = stat.out_free &&
                (((state_r == ST_META) && !(stat.is_deq && !stat.fifo_empty)) ||
                 (state_r == ST_POP));
    cmd.accept   = in_valid && in_ready_r;
    cmd.store_rd = pop_go;
    cmd.commit   = commit_go;
  end

  assign in_ready = in_ready_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid && in_ready_r) begin
            state_r    <= ST_META;
            in_ready_r <= 1'b0;
          end else begin
            in_ready_r <= 1'b1;
          end
        end
        ST_META: begin
          if (pop_go) begin
            state_r <= ST_POP;
          end else if (commit_go) begin
            state_r    <= ST_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        ST_POP: begin
          if (commit_go) begin
            state_r    <= ST_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        default: begin
          state_r    <= ST_IDLE;
          in_ready_r <= 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: sv/phq_dp.sv
// Datapath of the priority bucket queue: counters, FIFO state and handle store.
module phq_dp #(
  parameter int BUCKETS     = 8,
  parameter int FIFO_DEPTH  = 16,
  parameter int HANDLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  phq_pkg::ctrl_cmd_t                cmd,
  output phq_pkg::dp_stat_t                 stat,
  input  logic                              in_op,
  input  logic [phq_pkg::REQ_ID_W-1:0]      in_req_id,
  input  logic                              in_urgent,
  input  logic [phq_pkg::HANDLE_W-1:0]      in_handle,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [phq_pkg::STATUS_W-1:0]      out_status,
  output logic [phq_pkg::HANDLE_W-1:0]      out_handle,
  output logic [phq_pkg::BUCKET_W-1:0]      out_bucket,
  output logic [phq_pkg::TOTAL_W-1:0]       out_total,
  output logic [phq_pkg::URGENT_Q_W-1:0]    out_urgent
);

  localparam int NFIFO  = BUCKETS + 1;
  localparam int IW     = $clog2(NFIFO);
  localparam int PW     = $clog2(FIFO_DEPTH);
  localparam int FW     = $clog2(FIFO_DEPTH + 1);
  localparam int TW     = $clog2(NFIFO * FIFO_DEPTH + 1);
  localparam int SW     = (HANDLE_BITS < phq_pkg::HANDLE_W) ? HANDLE_BITS : phq_pkg::HANDLE_W;
  localparam int AW     = IW + PW;
  localparam int SDEPTH = NFIFO * (1 << PW);

  localparam logic [IW-1:0] URG_IDX = IW'(BUCKETS);
  localparam logic [IW-1:0] BMASK   = IW'(BUCKETS - 1);
  localparam logic [FW-1:0] DEPTH_F = FW'(FIFO_DEPTH);
  localparam logic [FW:0]   DEPTH_S = (FW + 1)'(FIFO_DEPTH);
  localparam logic [PW-1:0] LAST_H  = PW'(FIFO_DEPTH - 1);

  // Request latched at accept.
  logic          op_r;
  logic [IW-1:0] idx_r;
  logic [SW-1:0] hdl_r;

  // Per-FIFO read position and fill, with a valid bit per FIFO.
  logic [PW-1:0]    head_mem [NFIFO];
  logic [FW-1:0]    fill_mem [NFIFO];
  logic [NFIFO-1:0] meta_vld_r;
  logic [PW-1:0]    head_q_r;
  logic [FW-1:0]    fill_q_r;

  logic [SW-1:0] store_mem [SDEPTH];
  logic [SW-1:0] store_q_r;

  logic [TW-1:0] total_r;
  logic [FW-1:0] urg_cnt_r;
  logic [IW-1:0] rr_r;

  logic                            out_valid_r;
  logic [phq_pkg::STATUS_W-1:0]    out_status_r;
  logic [phq_pkg::HANDLE_W-1:0]    out_handle_r;
  logic [phq_pkg::BUCKET_W-1:0]    out_bucket_r;
  logic [phq_pkg::TOTAL_W-1:0]     out_total_r;
  logic [phq_pkg::URGENT_Q_W-1:0]  out_urgent_r;

  logic [IW-1:0]                idx_sel;
  logic [FW:0]                  pos_sum;
  logic [PW-1:0]                pos_wr;
  logic [PW-1:0]                head_inc;
  logic                         fifo_full;
  logic                         fifo_empty;
  logic                         chose_urg;
  logic [IW-1:0]                rr_inc;
  logic [phq_pkg::STATUS_W-1:0] status_nxt;
  logic [SW-1:0]                hdl_out;
  logic                         meta_we;
  logic                         store_we;
  logic [PW-1:0]                head_nxt;
  logic [FW-1:0]                fill_nxt;
  logic [TW-1:0]                total_nxt;
  logic [FW-1:0]                urg_cnt_nxt;
  logic [IW-1:0]                rr_nxt;

  always_comb begin
    if (in_op == phq_pkg::OP_DEQ) begin
      idx_sel = (urg_cnt_r != '0) ? URG_IDX : rr_r;
    end else begin
      idx_sel = in_urgent ? URG_IDX : (in_req_id[IW-1:0] & BMASK);
    end
  end

  always_comb begin
    pos_sum    = (FW + 1)'(head_q_r) + (FW + 1)'(fill_q_r);
    pos_wr     = (pos_sum >= DEPTH_S) ? PW'(pos_sum - DEPTH_S) : PW'(pos_sum);
    head_inc   = (head_q_r == LAST_H) ? '0 : head_q_r + PW'(1);
    fifo_full  = (fill_q_r == DEPTH_F);
    fifo_empty = (fill_q_r == '0);
    chose_urg  = (urg_cnt_r != '0);
    rr_inc     = (rr_r + IW'(1)) & BMASK;
  end

  always_comb begin
    status_nxt  = phq_pkg::STS_OK;
    hdl_out     = '0;
    meta_we     = 1'b0;
    store_we    = 1'b0;
    head_nxt    = head_q_r;
    fill_nxt    = fill_q_r;
    total_nxt   = total_r;
    urg_cnt_nxt = urg_cnt_r;
    rr_nxt      = rr_r;
    if (op_r == phq_pkg::OP_ENQ) begin
      if (fifo_full) begin
        status_nxt = phq_pkg::STS_FULL;
      end else begin
        store_we  = 1'b1;
        meta_we   = 1'b1;
        fill_nxt  = fill_q_r + FW'(1);
        total_nxt = total_r + TW'(1);
        if (total_r == '0) begin
          rr_nxt = idx_r;
        end
        if (idx_r == URG_IDX) begin
          urg_cnt_nxt = urg_cnt_r + FW'(1);
        end
      end
    end else begin
      if (!chose_urg) begin
        rr_nxt = rr_inc;
      end
      if (fifo_empty) begin
        status_nxt = phq_pkg::STS_EMPTY;
      end else begin
        hdl_out  = store_q_r;
        meta_we  = 1'b1;
        head_nxt = head_inc;
        fill_nxt = fill_q_r - FW'(1);
        if (total_r != '0) begin
          total_nxt = total_r - TW'(1);
        end
        if ((idx_r == URG_IDX) && chose_urg) begin
          urg_cnt_nxt = urg_cnt_r - FW'(1);
        end
      end
    end
  end

  always_comb begin
    stat.is_deq     = (op_r == phq_pkg::OP_DEQ);
    stat.fifo_empty = fifo_empty;
    stat.out_free   = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_vld_r  <= '0;
      total_r     <= '0;
      urg_cnt_r   <= '0;
      rr_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        total_r     <= total_nxt;
        urg_cnt_r   <= urg_cnt_nxt;
        rr_r        <= rr_nxt;
        out_valid_r <= 1'b1;
        if (meta_we) begin
          meta_vld_r[idx_r] <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r     <= in_op;
      idx_r    <= idx_sel;
      hdl_r    <= in_handle[SW-1:0];
      head_q_r <= meta_vld_r[idx_sel] ? head_mem[idx_sel] : '0;
      fill_q_r <= meta_vld_r[idx_sel] ? fill_mem[idx_sel] : '0;
    end
    if (cmd.commit && meta_we) begin
      head_mem[idx_r] <= head_nxt;
      fill_mem[idx_r] <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && store_we) begin
      store_mem[AW'({idx_r, pos_wr})] <= hdl_r;
    end
    if (cmd.store_rd) begin
      store_q_r <= store_mem[AW'({idx_r, head_q_r})];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= status_nxt;
      out_handle_r <= phq_pkg::HANDLE_W'(hdl_out);
      out_bucket_r <= phq_pkg::BUCKET_W'(idx_r);
      out_total_r  <= phq_pkg::TOTAL_W'(total_nxt);
      out_urgent_r <= phq_pkg::URGENT_Q_W'(urg_cnt_nxt);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_handle = out_handle_r;
  assign out_bucket = out_bucket_r;
  assign out_total  = out_total_r;
  assign out_urgent = out_urgent_r;

endmodule

FILE: sv/priority_hashed_bucket_queue.sv
// Top level of the priority bucket queue: strict-priority urgent FIFO over round-robin buckets.
//
//   Channel   Dir  Handshake      Word
//   in_req    in   valid/ready    op, req_id, urgent, handle
//   out_rsp   out  valid/ready    status, out_handle, bucket, total_queued, urgent_queued
//
// An enqueue or an empty dequeue goes from idle through the meta state; a dequeue that pops
// a handle adds the pop state, with the FIFO state read at accept and the store read in meta.
// Each word produces exactly one result word in a registered output stage.
// A new word is accepted while the previous result still waits in the output stage.
// A stalled output holds the next result back in the datapath until the stage frees up.
// Reset is synchronous and clears all counters and FIFO valid bits at once.
module priority_hashed_bucket_queue #(
  parameter int BUCKETS     = 8,
  parameter int FIFO_DEPTH  = 16,
  parameter int HANDLE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  phq_req_if.sink    in_req,
  phq_rsp_if.source  out_rsp
);

  phq_pkg::ctrl_cmd_t cmd;
  phq_pkg::dp_stat_t  stat;

  phq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  phq_dp #(
    .BUCKETS     (BUCKETS),
    .FIFO_DEPTH  (FIFO_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (in_req.op),
    .in_req_id  (in_req.req_id),
    .in_urgent  (in_req.urgent),
    .in_handle  (in_req.handle),
    .out_ready  (out_rsp.ready),
    .out_valid  (out_rsp.valid),
    .out_status (out_rsp.status),
    .out_handle (out_rsp.out_handle),
    .out_bucket (out_rsp.bucket),
    .out_total  (out_rsp.total_queued),
    .out_urgent (out_rsp.urgent_queued)
  );

endmodule

FILE: sv/phq_chk.sv
// Port-level assertion checker of the priority bucket queue and its bind.
`include "priority_hashed_bucket_queue_assert.svh"

module phq_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [phq_pkg::STATUS_W-1:0]      status,
  input logic [phq_pkg::HANDLE_W-1:0]      out_handle,
  input logic [phq_pkg::BUCKET_W-1:0]      bucket,
  input logic [phq_pkg::TOTAL_W-1:0]       total_queued,
  input logic [phq_pkg::URGENT_Q_W-1:0]    urgent_queued
);

  logic [1:0] pend_r;
  logic [1:0] pend_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Words accepted whose result has not yet been taken.
  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 2'd1;
    end else if (!in_acc && out_acc) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `PHQ_ASSERT_IMP(a_accept_room, clk, rst_n, in_acc, (pend_r != 2'd2) && (pend_r != 2'd3),
    "word accepted with two results outstanding")
  `PHQ_ASSERT_IMP(a_result_owed, clk, rst_n, out_valid, pend_r != 2'd0,
    "result shown without an accepted word")
  `PHQ_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_acc, !in_ready,
    "ready stayed high right after an accepted word")
  `PHQ_ASSERT_IMP(a_empty_no_urgent, clk, rst_n,
    out_valid && (status == phq_pkg::STS_EMPTY),
    (urgent_queued == '0) && (out_handle == '0),
    "empty result with urgent requests held or a nonzero handle")
  `PHQ_ASSERT_NXT(a_stall_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(status) && $stable(out_handle) && $stable(bucket) &&
    $stable(total_queued) && $stable(urgent_queued),
    "stalled result word changed")

endmodule

bind priority_hashed_bucket_queue phq_chk u_phq_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_req.valid),
  .in_ready      (in_req.ready),
  .out_valid     (out_rsp.valid),
  .out_ready     (out_rsp.ready),
  .status        (out_rsp.status),
  .out_handle    (out_rsp.out_handle),
  .bucket        (out_rsp.bucket),
  .total_queued  (out_rsp.total_queued),
  .urgent_queued (out_rsp.urgent_queued)
);

FILE: dv/priority_hashed_bucket_queue_tb.sv
// Self-checking testbench for the priority bucket queue with a predicted result per word.
`timescale 1ns / 100ps

module priority_hashed_bucket_queue_tb;

  localparam int BUCKETS     = 8;
  localparam int FIFO_DEPTH  = 16;
  localparam int HANDLE_BITS = 16;
  localparam int NUM_FIFOS   = BUCKETS + 1;
  localparam int RANDOM_WORDS = 1700;
  localparam int QUIET_AFTER  = 1400;
  localparam int LONG_HOLD    = 400;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic                         op;
    logic [phq_pkg::REQ_ID_W-1:0] req_id;
    logic                         urgent;
    logic [phq_pkg::HANDLE_W-1:0] handle;
  } req_word_t;

  typedef struct packed {
    logic [phq_pkg::STATUS_W-1:0]   status;
    logic [phq_pkg::HANDLE_W-1:0]   out_handle;
    logic [phq_pkg::BUCKET_W-1:0]   bucket;
    logic [phq_pkg::TOTAL_W-1:0]    total_queued;
    logic [phq_pkg::URGENT_Q_W-1:0] urgent_queued;
  } rsp_word_t;

  class queue_scoreboard;
    logic [phq_pkg::HANDLE_W-1:0] handle_mem [NUM_FIFOS][FIFO_DEPTH];
    int unsigned         rd_pos [NUM_FIFOS];
    int unsigned         depth_now [NUM_FIFOS];
    int unsigned         total_held;
    int unsigned         urgent_held;
    int unsigned         rr_ptr;
    rsp_word_t           expected_rsp[$];
    int                  mismatches;
    int                  checked;
    int                  drops;
    int                  empty_deqs;
    int                  urgent_pops;
    int                  bucket_pops;

    function new();
      for (int i = 0; i < NUM_FIFOS; i++) begin
        rd_pos[i] = 0;
        depth_now[i] = 0;
      end
      total_held = 0;
      urgent_held = 0;
      rr_ptr = 0;
      mismatches = 0;
      checked = 0;
      drops = 0;
      empty_deqs = 0;
      urgent_pops = 0;
      bucket_pops = 0;
    endfunction

    function void note_request(req_word_t w);
      rsp_word_t   r;
      int unsigned sel;
      int unsigned pos;
      r = '0;
      r.status = phq_pkg::STS_OK;
      if (w.op == phq_pkg::OP_ENQ) begin
        sel = w.urgent ? BUCKETS : int'(w.req_id & phq_pkg::REQ_ID_W'(BUCKETS - 1));
        if (depth_now[sel] >= FIFO_DEPTH) begin
          r.status = phq_pkg::STS_FULL;
          drops++;
        end else begin
          pos = (rd_pos[sel] + depth_now[sel]) % FIFO_DEPTH;
          handle_mem[sel][pos] = w.handle & phq_pkg::HANDLE_W'((1 << HANDLE_BITS) - 1);
          depth_now[sel]++;
          total_held++;
          if (total_held == 1) rr_ptr = sel;
          if (sel == BUCKETS) urgent_held++;
        end
      end else begin
        if (urgent_held > 0) begin
          sel = BUCKETS;
        end else begin
          sel = (rr_ptr > BUCKETS) ? BUCKETS : rr_ptr;
          rr_ptr = (rr_ptr + 1) & (BUCKETS - 1);
        end
        if (depth_now[sel] == 0) begin
          r.status = phq_pkg::STS_EMPTY;
          empty_deqs++;
        end else begin
          r.out_handle = handle_mem[sel][rd_pos[sel]];
          rd_pos[sel] = (rd_pos[sel] + 1) % FIFO_DEPTH;
          depth_now[sel]--;
          total_held--;
          if (sel == BUCKETS) begin
            urgent_held--;
            urgent_pops++;
          end else begin
            bucket_pops++;
          end
        end
      end
      r.bucket = phq_pkg::BUCKET_W'(sel);
      r.total_queued = phq_pkg::TOTAL_W'(total_held);
      r.urgent_queued = phq_pkg::URGENT_Q_W'(urgent_held);
      expected_rsp.push_back(r);
    endfunction

    function void check_result(rsp_word_t got);
      rsp_word_t want;
      bit        bad;
      checked++;
      if (expected_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] ERROR: result word with none expected:", $realtime,
                   " sts=%0d hdl=%h bkt=%0d tot=%0d urg=%0d",
                   got.status, got.out_handle, got.bucket, got.total_queued,
                   got.urgent_queued);
        return;
      end
      want = expected_rsp.pop_front();
      bad = (got.status !== want.status) || (got.out_handle !== want.out_handle) ||
            (got.bucket !== want.bucket) || (got.total_queued !== want.total_queued) ||
            (got.urgent_queued !== want.urgent_queued);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] ERROR: expected sts=%0d hdl=%h bkt=%0d tot=%0d urg=%0d,",
                   $realtime, want.status, want.out_handle, want.bucket, want.total_queued,
                   want.urgent_queued,
                   " got sts=%0d hdl=%h bkt=%0d tot=%0d urg=%0d",
                   got.status, got.out_handle, got.bucket,
                   got.total_queued, got.urgent_queued);
      end
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  phq_req_if in_req ();
  phq_rsp_if out_rsp ();

  priority_hashed_bucket_queue #(
    .BUCKETS     (BUCKETS),
    .FIFO_DEPTH  (FIFO_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  queue_scoreboard sb = new();
  bit              quiet = 1'b0;
  bit              hold_request = 1'b0;
  int              words_sent = 0;
  int unsigned     cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, sb.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_req.valid && in_req.ready)
      sb.note_request('{in_req.op, in_req.req_id, in_req.urgent, in_req.handle});
    if (rst_n && out_rsp.valid && out_rsp.ready)
      sb.check_result('{out_rsp.status, out_rsp.out_handle, out_rsp.bucket,
                        out_rsp.total_queued, out_rsp.urgent_queued});
  end

  initial begin
    out_rsp.ready <= 1'b0;
    @(posedge clk);
    out_rsp.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_rsp.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_rsp.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_rsp.ready <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic op, input logic [phq_pkg::REQ_ID_W-1:0] rid,
                           input logic urg, input logic [phq_pkg::HANDLE_W-1:0] hdl);
    int unsigned gap;
    in_req.valid  <= 1'b1;
    in_req.op     <= op;
    in_req.req_id <= rid;
    in_req.urgent <= urg;
    in_req.handle <= hdl;
    do @(posedge clk); while (!in_req.ready);
    words_sent++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_all_results();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    send_word(phq_pkg::OP_DEQ, 32'h0, 1'b0, 16'h0);
    send_word(phq_pkg::OP_ENQ, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
    send_word(phq_pkg::OP_DEQ, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
    send_word(phq_pkg::OP_DEQ, 32'h0, 1'b0, 16'h0);
    send_word(phq_pkg::OP_DEQ, 32'h0, 1'b0, 16'h0);
    send_word(phq_pkg::OP_ENQ, 32'hFFFF_FFFF, 1'b0, 16'h0000);
    send_word(phq_pkg::OP_ENQ, 32'h0, 1'b0, 16'hFFFF);
    for (int i = 0; i < FIFO_DEPTH; i++)
      send_word(phq_pkg::OP_ENQ, {29'($urandom_range(0, 32'h1FFF_FFFF)), 3'd7}, 1'b0,
                16'(i * 16'h1111));
    send_word(phq_pkg::OP_DEQ, 32'h0, 1'b0, 16'h0);
    send_word(phq_pkg::OP_DEQ, 32'h0, 1'b0, 16'h0);
  endtask

  task automatic run_random();
    int unsigned                   phase_len;
    int unsigned                   kind;
    int unsigned                   enq_pct;
    int unsigned                   urg_pct;
    int unsigned                   hot_pct;
    logic [2:0]                    hot_bucket;
    logic [phq_pkg::REQ_ID_W-1:0]  rid;
    bit                            hold_done;
    bit                            drained_mid;
    int                            start;
    start = words_sent;
    hold_done = 1'b0;
    drained_mid = 1'b0;
    while (words_sent - start < RANDOM_WORDS) begin
      phase_len = $urandom_range(40, 160);
      kind = $urandom_range(0, 3);
      case (kind)
        0: begin enq_pct = 85; urg_pct = 15; end
        1: begin enq_pct = 20; urg_pct = 15; end
        2: begin enq_pct = 50; urg_pct = 15; end
        default: begin enq_pct = 85; urg_pct = 70; end
      endcase
      hot_pct = ($urandom_range(0, 1) == 0) ? 0 : 60;
      hot_bucket = 3'($urandom_range(0, BUCKETS - 1));
      for (int i = 0; i < phase_len && words_sent - start < RANDOM_WORDS; i++) begin
        if (words_sent - start >= QUIET_AFTER) quiet = 1'b1;
        if (!hold_done && words_sent - start >= 700) begin
          hold_request = 1'b1;
          hold_done = 1'b1;
        end
        rid = $urandom();
        if ($urandom_range(0, 99) < hot_pct) rid[2:0] = hot_bucket;
        send_word(($urandom_range(0, 99) < enq_pct) ? phq_pkg::OP_ENQ : phq_pkg::OP_DEQ, rid,
                  $urandom_range(0, 99) < urg_pct, 16'($urandom()));
      end
      if ((!drained_mid && words_sent - start >= 1000) || $urandom_range(0, 3) == 0) begin
        drained_mid = 1'b1;
        in_req.valid <= 1'b0;
        wait_all_results();
      end
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_req.valid  <= 1'b0;
    in_req.op     <= phq_pkg::OP_ENQ;
    in_req.req_id <= '0;
    in_req.urgent <= 1'b0;
    in_req.handle <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    in_req.valid <= 1'b0;
    wait_all_results();
    run_random();
    in_req.valid <= 1'b0;
    wait_all_results();
    repeat (20) @(posedge clk);
    $display("Sent %0d request words and checked %0d result words.", words_sent, sb.checked);
    $display("Covered %0d urgent pops, %0d bucket pops, %0d empty dequeues, %0d full drops.",
             sb.urgent_pops, sb.bucket_pops, sb.empty_deqs, sb.drops);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.mismatches, sb.pending());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
